FILE: hw/rtl/fmd_pkg.sv
// Package for the framed message decoder: result codes, header kinds,
// register indexes and the structs passed between the capture and check logic.
// No dependencies.
`default_nettype none

package fmd_pkg;

    localparam int unsigned HEADER_LEN  = 12;
    localparam int unsigned STORE_BYTES = 20;
    localparam int unsigned STORE_IDX_W = $clog2(STORE_BYTES);

    typedef enum logic [3:0] {
        ERR_OK       = 4'd0,
        ERR_TRUNC    = 4'd1,
        ERR_MAGIC    = 4'd2,
        ERR_VERSION  = 4'd3,
        ERR_LENGTH   = 4'd4,
        ERR_HELLO    = 4'd5,
        ERR_INPUT    = 4'd6,
        ERR_SNAPSHOT = 4'd7,
        ERR_KIND     = 4'd8
    } err_t;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_HELLO    = 3'd1,
        KIND_INPUT    = 3'd2,
        KIND_COMPLETE = 3'd3,
        KIND_SNAPSHOT = 3'd4
    } kind_t;

    localparam logic [15:0] HDR_KIND_HELLO    = 16'd1;
    localparam logic [15:0] HDR_KIND_INPUT    = 16'd2;
    localparam logic [15:0] HDR_KIND_COMPLETE = 16'd3;
    localparam logic [15:0] HDR_KIND_SNAPSHOT = 16'd4;

    localparam logic [31:0] LEN_HELLO    = 32'd5;
    localparam logic [31:0] LEN_INPUT    = 32'd8;
    localparam logic [31:0] LEN_COMPLETE = 32'd0;
    localparam logic [31:0] LEN_SNAPSHOT = 32'd20;

    typedef enum logic [1:0] {
        CFG_MAGIC   = 2'd0,
        CFG_VERSION = 2'd1,
        CFG_ROLE_A  = 2'd2,
        CFG_ROLE_B  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0]                  magic;
        logic [15:0]                  version;
        logic [15:0]                  kind;
        logic [31:0]                  length;
        logic [STORE_BYTES-1:0][7:0]  payload;
    } frame_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [7:0]  role_a;
        logic [7:0]  role_b;
    } cfg_t;

    typedef struct packed {
        err_t               error_code;
        kind_t              message_kind;
        logic [31:0]        peer_id;
        logic [7:0]         client_role;
        logic [31:0]        tick_number;
        logic signed [63:0] signed_value;
        logic [63:0]        digest_value;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fmd_if.sv
// Request channel interfaces of the framed message decoder: byte input
// and decoded result output. No dependencies.
`default_nettype none

interface fmd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fmd_result_if;
    logic               valid;
    logic               ready;
    logic [3:0]         error_code;
    logic [2:0]         message_kind;
    logic [31:0]        peer_id;
    logic [7:0]         client_role;
    logic [31:0]        tick_number;
    logic signed [63:0] signed_value;
    logic [63:0]        digest_value;

    modport source (output valid, output error_code, output message_kind,
                    output peer_id, output client_role, output tick_number,
                    output signed_value, output digest_value, input ready);
    modport sink   (input valid, input error_code, input message_kind,
                    input peer_id, input client_role, input tick_number,
                    input signed_value, input digest_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fmd_capture.sv
// Byte counter, header capture and payload byte store of the decoder.
// Presents the frame including the current byte. Depends on fmd_pkg.
`default_nettype none

module fmd_capture #(
    parameter int unsigned MAX_PAYLOAD = 64,
    parameter int unsigned CNT_W       = 7
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    output fmd_pkg::frame_t         frame_view,
    output logic [CNT_W-1:0]        count_view
);

    localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(fmd_pkg::HEADER_LEN + MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] HDR_LEN   = CNT_W'(fmd_pkg::HEADER_LEN);

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [CNT_W-1:0]                   pay_off;
    logic [fmd_pkg::STORE_IDX_W-1:0]    pay_idx;
    logic [31:0]                        magic_reg;
    logic [15:0]                        version_reg;
    logic [15:0]                        kind_reg;
    logic [31:0]                        length_reg;
    logic [fmd_pkg::STORE_BYTES-1:0][7:0] store_reg;

    assign pay_off = count_reg - HDR_LEN;
    assign pay_idx = pay_off[fmd_pkg::STORE_IDX_W-1:0];

    always_comb
    begin
        frame_view.magic   = magic_reg;
        frame_view.version = version_reg;
        frame_view.kind    = kind_reg;
        frame_view.length  = length_reg;
        frame_view.payload = store_reg;
        priority if (count_reg < CNT_W'(4))
        begin
            frame_view.magic[{count_reg[1:0], 3'b000} +: 8] = data_byte;
        end
        else if (count_reg < CNT_W'(6))
        begin
            frame_view.version[{count_reg[0], 3'b000} +: 8] = data_byte;
        end
        else if (count_reg < CNT_W'(8))
        begin
            frame_view.kind[{count_reg[0], 3'b000} +: 8] = data_byte;
        end
        else if (count_reg < HDR_LEN)
        begin
            frame_view.length[{count_reg[1:0], 3'b000} +: 8] = data_byte;
        end
        else if (pay_off < CNT_W'(fmd_pkg::STORE_BYTES))
        begin
            frame_view.payload[pay_idx] = data_byte;
        end
        else
        begin
            frame_view.payload = store_reg;
        end
    end

    assign count_view = (count_reg < COUNT_SAT) ? count_reg + CNT_W'(1) : count_reg;
    assign count_next = last_byte ? '0 : count_view;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            magic_reg   <= '0;
            version_reg <= '0;
            kind_reg    <= '0;
            length_reg  <= '0;
        end
        else if (step)
        begin
            count_reg   <= count_next;
            magic_reg   <= frame_view.magic;
            version_reg <= frame_view.version;
            kind_reg    <= frame_view.kind;
            length_reg  <= frame_view.length;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            store_reg <= frame_view.payload;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fmd_judge.sv
// Message checks and field decode of the decoder, from the frame view
// and byte count. Depends on fmd_pkg.
`default_nettype none

module fmd_judge #(
    parameter int unsigned MAX_PAYLOAD = 64,
    parameter int unsigned CNT_W       = 7
) (
    input  wire fmd_pkg::frame_t   frame_view,
    input  wire logic [CNT_W-1:0]  count_view,
    input  wire fmd_pkg::cfg_t     cfg,
    output fmd_pkg::res_t          res
);

    logic [32:0]                          count_ext;
    logic [32:0]                          frame_total;
    logic                                 len_bad;
    logic [7:0]                           role;
    logic [fmd_pkg::STORE_BYTES-1:0][7:0] p;
    fmd_pkg::err_t                        err;
    fmd_pkg::res_t                        dec;

    assign p           = frame_view.payload;
    assign role        = p[4];
    assign count_ext   = 33'(count_view);
    assign frame_total = {1'b0, frame_view.length} + 33'(fmd_pkg::HEADER_LEN);
    assign len_bad     = (frame_view.length > 32'(MAX_PAYLOAD)) || (count_ext != frame_total);

    always_comb
    begin
        dec = '0;
        err = fmd_pkg::ERR_OK;
        priority if (count_view < CNT_W'(fmd_pkg::HEADER_LEN))
        begin
            err = fmd_pkg::ERR_TRUNC;
        end
        else if (frame_view.magic != cfg.magic)
        begin
            err = fmd_pkg::ERR_MAGIC;
        end
        else if (frame_view.version != cfg.version)
        begin
            err = fmd_pkg::ERR_VERSION;
        end
        else if (len_bad)
        begin
            err = fmd_pkg::ERR_LENGTH;
        end
        else
        begin
            unique case (frame_view.kind)
                fmd_pkg::HDR_KIND_HELLO:
                begin
                    if (frame_view.length != fmd_pkg::LEN_HELLO
                        || (role != cfg.role_a && role != cfg.role_b))
                    begin
                        err = fmd_pkg::ERR_HELLO;
                    end
                    dec.message_kind = fmd_pkg::KIND_HELLO;
                    dec.peer_id      = p[3:0];
                    dec.client_role  = role;
                end
                fmd_pkg::HDR_KIND_INPUT:
                begin
                    if (frame_view.length != fmd_pkg::LEN_INPUT)
                    begin
                        err = fmd_pkg::ERR_INPUT;
                    end
                    dec.message_kind = fmd_pkg::KIND_INPUT;
                    dec.tick_number  = p[3:0];
                    dec.signed_value = {{32{p[7][7]}}, p[7:4]};
                end
                fmd_pkg::HDR_KIND_COMPLETE:
                begin
                    if (frame_view.length != fmd_pkg::LEN_COMPLETE)
                    begin
                        err = fmd_pkg::ERR_KIND;
                    end
                    dec.message_kind = fmd_pkg::KIND_COMPLETE;
                end
                fmd_pkg::HDR_KIND_SNAPSHOT:
                begin
                    if (frame_view.length != fmd_pkg::LEN_SNAPSHOT)
                    begin
                        err = fmd_pkg::ERR_SNAPSHOT;
                    end
                    dec.message_kind = fmd_pkg::KIND_SNAPSHOT;
                    dec.tick_number  = p[3:0];
                    dec.signed_value = p[11:4];
                    dec.digest_value = p[19:12];
                end
                default:
                begin
                    err = fmd_pkg::ERR_KIND;
                end
            endcase
        end
        if (err != fmd_pkg::ERR_OK)
        begin
            dec = '0;
        end
        dec.error_code = err;
        res = dec;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/framed_message_decoder.sv
// Framed message decoder top level: input register, capture, checks and
// result register. Depends on fmd_pkg, fmd_if, fmd_capture and fmd_judge.
//
// Usage:
//   in_ch carries one message byte per request, last_byte set on the final
//   byte. out_ch carries one decoded result per message, presented after the
//   final byte: header is 12 bytes little-endian (magic, version, kind,
//   payload length), then the payload.
//   Throughput is one byte per cycle, except while a final byte waits on a
//   stalled out_ch. A byte passes the input register and the check logic
//   into the result register, which takes the result with the final byte.
//   The result register holds a finished result while out_ch is stalled; the
//   next message streams in until its own final byte, which waits in the
//   input register until the result ahead is taken.
//   Registers are written through cfg_we / cfg_index / cfg_data; the user
//   must write them only while no message is in flight, which the block
//   does not enforce. Reset clears the byte count, captured header, both
//   valid flags and the registers (role B resets to 1); no clearing pass is needed.
`default_nettype none

module framed_message_decoder #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    fmd_byte_if.sink           in_ch,
    fmd_result_if.source       out_ch,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int unsigned CNT_W = $clog2(fmd_pkg::HEADER_LEN + MAX_PAYLOAD + 2);

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_last_reg;
    logic               s1_go;
    logic               out_valid_reg;
    logic               out_valid_next;
    fmd_pkg::res_t      res_reg;
    fmd_pkg::res_t      res_comb;
    fmd_pkg::cfg_t      cfg_reg;
    fmd_pkg::frame_t    frame_view;
    logic [CNT_W-1:0]   count_view;
    fmd_pkg::cfg_idx_t  cfg_sel;

    assign s1_go       = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_byte_reg <= in_ch.data_byte;
            s1_last_reg <= in_ch.last_byte;
        end
    end

    fmd_capture #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CNT_W       (CNT_W)
    ) u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s1_go),
        .data_byte  (s1_byte_reg),
        .last_byte  (s1_last_reg),
        .frame_view (frame_view),
        .count_view (count_view)
    );

    fmd_judge #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CNT_W       (CNT_W)
    ) u_judge (
        .frame_view (frame_view),
        .count_view (count_view),
        .cfg        (cfg_reg),
        .res        (res_comb)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (s1_go && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            res_reg <= res_comb;
        end
    end

    assign cfg_sel = fmd_pkg::cfg_idx_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic   <= '0;
            cfg_reg.version <= '0;
            cfg_reg.role_a  <= 8'd0;
            cfg_reg.role_b  <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                fmd_pkg::CFG_MAGIC:   cfg_reg.magic   <= cfg_data;
                fmd_pkg::CFG_VERSION: cfg_reg.version <= cfg_data[15:0];
                fmd_pkg::CFG_ROLE_A:  cfg_reg.role_a  <= cfg_data[7:0];
                fmd_pkg::CFG_ROLE_B:  cfg_reg.role_b  <= cfg_data[7:0];
                default:              cfg_reg         <= cfg_reg;
            endcase
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.error_code   = res_reg.error_code;
    assign out_ch.message_kind = res_reg.message_kind;
    assign out_ch.peer_id      = res_reg.peer_id;
    assign out_ch.client_role  = res_reg.client_role;
    assign out_ch.tick_number  = res_reg.tick_number;
    assign out_ch.signed_value = res_reg.signed_value;
    assign out_ch.digest_value = res_reg.digest_value;

endmodule

`default_nettype wire
